/* sv/ptm_pkg.sv */
// Shared types and codes for the packet target match table.
package ptm_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int IDX_W  = 4;
  localparam int MODE_W = 2;

  // Request kinds.
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Lookup modes.
  localparam logic [MODE_W-1:0] MODE_PORT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADDR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALL  = 2'd2;

  // One request as it travels down the chain, with the hit collected so far.
  typedef struct packed {
    logic              vld;
    logic              action;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  entry_index;
    logic              entry_valid;
    logic [ADDR_W-1:0] dest_addr;
    logic [PORT_W-1:0] dest_port;
    logic [PORT_W-1:0] source_port;
    logic              hit;
  } req_t;

endpackage

/* sv/packet_target_match_table_top.sv */
// Top level of the packet target match table: input, cell chain and result register.
//
// Requests enter on the in_ channel. A write request (in_action = 0) stores
// an entry at in_entry_index and gives no result; a lookup request
// (in_action = 1) gives one result on the out_ channel, out_target_match.
// Each table entry lives in its own cell, and the cells form a chain of
// TABLE_ENTRIES stages. A request visits one cell per cycle unless the chain
// holds, so writes and lookups keep their order and a lookup sees exactly
// the writes ahead of it. A lookup passes all cells and then the result
// register before out_valid; one request is accepted every cycle while the
// result side takes results. When out_valid and out_stall are both high, the
// whole chain holds and in_stall goes high until the result is taken.
// Reset (rst_n low at a clock edge) marks every entry invalid and empties
// the chain and the result register; the block accepts requests in the
// first cycle after reset.
module packet_target_match_table_top
  import ptm_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic              in_entry_valid,
  input  logic [ADDR_W-1:0] in_dest_addr,
  input  logic [PORT_W-1:0] in_dest_port,
  input  logic [PORT_W-1:0] in_source_port,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_target_match
);

  req_t req_head;
  req_t stg [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] stg_vld;
  logic advance;
  logic out_valid_r;
  logic out_match_r;
  logic last_lookup;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  always_comb begin
    req_head.vld         = in_valid;
    req_head.action      = in_action;
    req_head.mode        = in_mode;
    req_head.entry_index = in_entry_index;
    req_head.entry_valid = in_entry_valid;
    req_head.dest_addr   = in_dest_addr;
    req_head.dest_port   = in_dest_port;
    req_head.source_port = in_source_port;
    req_head.hit         = 1'b0;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_first
      ptm_cell #(.CELL_ID(g)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req_in  (req_head),
        .req_out (stg[g])
      );
    end else begin : g_next
      ptm_cell #(.CELL_ID(g)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .req_in  (stg[g-1]),
        .req_out (stg[g])
      );
    end
    assign stg_vld[g] = stg[g].vld;
  end

  assign last_lookup = stg[TABLE_ENTRIES-1].vld &&
                       (stg[TABLE_ENTRIES-1].action == ACT_LOOKUP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= last_lookup;
      out_match_r <= stg[TABLE_ENTRIES-1].hit;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_target_match = out_match_r;

  // A result only comes from a lookup leaving the last cell.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(last_lookup))
    else $error("result without a lookup at the end of the chain");

  // The chain holds as a whole while a result waits.
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(stg_vld))
    else $error("chain moved while the result was stalled");

  // A result leaves only after it was taken.
  a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!out_stall))
    else $error("result dropped while stalled");

endmodule

/* sv/ptm_cell.sv */
// One table cell: holds one entry and one pipeline stage of the request chain.
module ptm_cell
  import ptm_pkg::*;
#(
  parameter int CELL_ID = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  req_t req_in,
  output req_t req_out
);

  logic [ADDR_W-1:0] ent_addr_r;
  logic [PORT_W-1:0] ent_dport_r;
  logic [PORT_W-1:0] ent_sport_r;
  logic              ent_valid_r;
  req_t              req_r;
  req_t              req_nxt;

  logic sel;
  logic wr_en;
  logic hit;
  logic a_eq;
  logic d_eq;
  logic s_eq;

  assign sel   = 32'(req_in.entry_index) == 32'(CELL_ID);
  assign wr_en = advance && req_in.vld && (req_in.action == ACT_WRITE) && sel;

  assign a_eq = ent_addr_r == req_in.dest_addr;
  assign d_eq = ent_dport_r == req_in.dest_port;
  assign s_eq = ent_sport_r == req_in.source_port;

  always_comb begin
    case (req_in.mode)
      MODE_PORT: hit = d_eq;
      MODE_ADDR: hit = a_eq;
      MODE_ALL:  hit = a_eq && d_eq && s_eq;
      default:   hit = 1'b0;
    endcase
  end

  always_comb begin
    req_nxt = req_in;
    if (req_in.action == ACT_LOOKUP) begin
      req_nxt.hit = req_in.hit || (ent_valid_r && hit);
    end else begin
      req_nxt.hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (wr_en) begin
      ent_valid_r <= req_in.entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_addr_r  <= req_in.dest_addr;
      ent_dport_r <= req_in.dest_port;
      ent_sport_r <= req_in.source_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.vld <= 1'b0;
    end else if (advance) begin
      req_r <= req_nxt;
    end
  end

  assign req_out = req_r;

  // A write request never carries a hit.
  a_write_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (req_r.vld && req_r.action == ACT_WRITE) |-> !req_r.hit)
    else $error("write request carries a hit");

  // The entry only changes on a write addressed to this cell.
  a_entry_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(ent_valid_r))
    else $error("entry valid changed without a write");

  // A stalled chain keeps this stage.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(req_r.vld))
    else $error("stage moved while the chain was stalled");

endmodule
